// ===== rtl/trd_pkg.sv =====
// Shared types and constants of the TGA run-length decoder.
// No dependencies; every other file of the block imports this package.
package trd_pkg;

  // Pixel counter sizing: the image total saturates at 2**PIXEL_COUNT_BITS.
  localparam int PIXEL_COUNT_BITS = 24;

  // Field and register widths.
  localparam int BYTE_W    = 8;
  localparam int PIXEL_W   = 32;
  localparam int COUNT_W   = 8;
  localparam int BPP_W     = 3;
  localparam int CFG_TOT_W = 25;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 25;

  // Internal pixel count width: wide enough for the register and the cap.
  localparam int TOT_W = (PIXEL_COUNT_BITS + 1 > CFG_TOT_W) ? PIXEL_COUNT_BITS + 1 : CFG_TOT_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BPP   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [BPP_W-1:0]     BPP_RST   = 3'd3;
  localparam logic [CFG_TOT_W-1:0] TOTAL_RST = 25'd1;

  // Packet header split and run bias.
  localparam logic [BYTE_W-1:0] HEADER_SPLIT = 8'd128;
  localparam logic [BYTE_W-1:0] RUN_BIAS     = 8'd127;

  // Decoder phase codes.
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_RAW    = 2'd1;
  localparam logic [1:0] PH_RUN    = 2'd2;

  // Output queue depth.
  localparam int QUEUE_DEPTH = 3;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 2;

  // One result beat.
  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_value;
    logic [COUNT_W-1:0] repeat_count;
    logic               image_last;
    logic               overflow;
  } trd_result_t;

endpackage

// ===== rtl/trd_core.sv =====
// Packet decoder of the TGA run-length decoder: input register, config
// registers, packet state and the single-pass decode logic. Uses trd_pkg.
module trd_core import trd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i,
  input  logic                 byte_accept_i,
  input  logic [BYTE_W-1:0]    byte_i,
  output logic                 busy_o,
  output logic                 res_valid_o,
  output trd_result_t          res_o
);

  localparam logic [TOT_W-1:0] TotCap = TOT_W'(1) << PIXEL_COUNT_BITS;

  logic                 in_valid_q;
  logic [BYTE_W-1:0]    byte_q;
  logic [BPP_W-1:0]     bpp_q;
  logic [CFG_TOT_W-1:0] total_cfg_q;

  logic [1:0]           phase_q, phase_d;
  logic [COUNT_W-1:0]   rem_q, rem_d;
  logic [1:0]           idx_q, idx_d;
  logic [PIXEL_W-1:0]   asm_q, asm_d;
  logic [TOT_W-1:0]     done_q, done_d;

  logic [1:0]           last_idx;
  logic [TOT_W-1:0]     total_raw, total_eff, left, done_sum;
  logic [PIXEL_W-1:0]   pixel;
  logic [COUNT_W-1:0]   count;
  logic                 ovf, img_last, res_valid;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= byte_accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_accept_i) begin
      byte_q <= byte_i;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q       <= BPP_RST;
      total_cfg_q <= TOTAL_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BPP:   bpp_q       <= cfg_wdata_i[BPP_W-1:0];
        CFG_TOTAL: total_cfg_q <= cfg_wdata_i[CFG_TOT_W-1:0];
        default:   ;
      endcase
    end
  end

  // Clamp the configuration into its working range.
  always_comb begin
    if (bpp_q == '0) begin
      last_idx = 2'd0;
    end else if (bpp_q > 3'd4) begin
      last_idx = 2'd3;
    end else begin
      last_idx = 2'(bpp_q - 3'd1);
    end
    total_raw = TOT_W'(total_cfg_q);
    if (total_raw == '0) begin
      total_eff = TOT_W'(1);
    end else if (total_raw > TotCap) begin
      total_eff = TotCap;
    end else begin
      total_eff = total_raw;
    end
  end

  // Decode one byte.
  always_comb begin
    phase_d   = phase_q;
    rem_d     = rem_q;
    idx_d     = idx_q;
    asm_d     = asm_q;
    done_d    = done_q;
    res_valid = 1'b0;
    ovf       = 1'b0;
    count     = COUNT_W'(1);
    pixel     = asm_q | (PIXEL_W'(byte_q) << {idx_q, 3'b000});
    left      = (total_eff > done_q) ? total_eff - done_q : TOT_W'(1);
    if (phase_q == PH_RUN) begin
      if (TOT_W'(rem_q) > left) begin
        count = left[COUNT_W-1:0];
        ovf   = 1'b1;
      end else begin
        count = rem_q;
      end
    end else begin
      ovf = (left == TOT_W'(1)) && (rem_q > COUNT_W'(1));
    end
    done_sum = done_q + TOT_W'(count);
    img_last = done_sum >= total_eff;

    if (in_valid_q) begin
      if (phase_q != PH_RAW && phase_q != PH_RUN) begin
        // Header byte: open a packet.
        if (byte_q < HEADER_SPLIT) begin
          phase_d = PH_RAW;
          rem_d   = byte_q + COUNT_W'(1);
        end else begin
          phase_d = PH_RUN;
          rem_d   = byte_q - RUN_BIAS;
        end
        idx_d = 2'd0;
        asm_d = '0;
      end else if (idx_q < last_idx) begin
        // Gather another pixel byte.
        idx_d = idx_q + 2'd1;
        asm_d = pixel;
      end else begin
        res_valid = 1'b1;
        idx_d     = 2'd0;
        asm_d     = '0;
        if (img_last) begin
          phase_d = PH_HEADER;
          rem_d   = '0;
          done_d  = '0;
        end else if (phase_q == PH_RAW && rem_q > COUNT_W'(1)) begin
          rem_d  = rem_q - COUNT_W'(1);
          done_d = done_sum;
        end else begin
          phase_d = PH_HEADER;
          rem_d   = '0;
          done_d  = done_sum;
        end
      end
    end
  end

  // Packet state; a config write restarts the image.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      rem_q   <= '0;
      idx_q   <= 2'd0;
      asm_q   <= '0;
      done_q  <= '0;
    end else if (cfg_we_i) begin
      phase_q <= PH_HEADER;
      rem_q   <= '0;
      idx_q   <= 2'd0;
      asm_q   <= '0;
      done_q  <= '0;
    end else begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      idx_q   <= idx_d;
      asm_q   <= asm_d;
      done_q  <= done_d;
    end
  end

  assign busy_o               = in_valid_q;
  assign res_valid_o          = res_valid;
  assign res_o.pixel_value    = pixel;
  assign res_o.repeat_count   = count;
  assign res_o.image_last     = img_last;
  assign res_o.overflow       = ovf;

`ifndef SYNTHESIS
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_o.repeat_count != '0)
    else $error("result with zero repeat count");

  a_ovf_ends_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.overflow) |-> res_o.image_last)
    else $error("overflow on a result that does not end the image");

  a_done_below_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(cfg_we_i) |-> done_q < total_eff)
    else $error("pixel count reached the total without a restart");
`endif

endmodule

// ===== rtl/trd_outq.sv =====
// Three-entry result queue that parts the decoder from the output channel.
// Uses trd_pkg.
module trd_outq import trd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  trd_result_t       push_data_i,
  input  logic              pop_i,
  output logic              not_empty_o,
  output logic [QCNT_W-1:0] level_o,
  output trd_result_t       head_o
);

  trd_result_t       mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign not_empty_o = cnt_q != '0;
  assign level_o     = cnt_q;
  assign head_o      = mem_q[rd_ptr_q];

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |-> cnt_q != QCNT_W'(QUEUE_DEPTH))
    else $error("result queue overrun");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> wr_ptr_q == rd_ptr_q)
    else $error("empty queue with unequal pointers");
`endif

endmodule

// ===== rtl/tga_rle_decoder_unit.sv =====
// Top level of the TGA run-length decoder: channel handshakes, decoder
// core and result queue. Uses trd_pkg, trd_core and trd_outq.

// The decoder takes the run-length packet stream of a TGA image one byte
// per beat and sustains one byte per clock cycle. A header byte below 128
// opens a raw packet of header+1 literal pixels, each given as one result
// beat with repeat_count 1; a header of 128 or more opens a run of
// header-127 pixels, given as a single result beat once its pixel bytes
// have arrived. Pixel bytes are packed first byte in bits 7:0, unused high
// bytes zero. Register 0 sets bytes per pixel (0 acts as 1, above 4 acts
// as 4), register 1 the pixel total of an image (0 acts as 1, large values
// saturate at 2**24). When the total is reached the result beat carries
// image_last and the decoder expects a new header; a packet that runs past
// the total is clamped, flagged with overflow, and its leftover pixels are
// dropped. Any register write restarts the decoder; write only while idle.
// Each accepted byte passes an input register and the combinational decode
// logic, and the result that it completes is written to the output queue.
// A three-entry result queue holds results while the output
// stalls; input stalls only when that queue together with the byte in the
// input register could fill it, which keeps the one-byte-per-cycle rate
// whenever the output takes a beat per cycle.
module tga_rle_decoder_unit import trd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [BYTE_W-1:0]    stream_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [PIXEL_W-1:0]   pixel_value_o,
  output logic [COUNT_W-1:0]   repeat_count_o,
  output logic                 image_last_o,
  output logic                 overflow_o
);

  logic              in_accept;
  logic              out_accept;
  logic              core_busy;
  logic              res_valid;
  trd_result_t       res;
  trd_result_t       head;
  logic [QCNT_W-1:0] level;
  logic [QCNT_W:0]   pending;

  // Queued results plus the byte in flight must leave room for one more.
  assign pending    = {1'b0, level} + (QCNT_W+1)'(core_busy);
  assign in_stall_o = pending >= (QCNT_W+1)'(QUEUE_DEPTH);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_accept = out_valid_o && !out_stall_i;

  trd_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .byte_accept_i (in_accept),
    .byte_i        (stream_byte_i),
    .busy_o        (core_busy),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  trd_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .pop_i       (out_accept),
    .not_empty_o (out_valid_o),
    .level_o     (level),
    .head_o      (head)
  );

  // Present the head of the queue.
  assign pixel_value_o  = head.pixel_value;
  assign repeat_count_o = head.repeat_count;
  assign image_last_o   = head.image_last;
  assign overflow_o     = head.overflow;

`ifndef SYNTHESIS
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> level != QCNT_W'(QUEUE_DEPTH))
    else $error("decoder produced a result with the queue full");
`endif

endmodule
